### rtl/core/lcsd_pkg.sv
`default_nettype none

package lcsd_pkg;

	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] raw_code;
	} lcsd_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] weight;
		logic [2:0]  still_count;
	} lcsd_out_t;

	// item kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_TICK   = 2'd1;
	localparam logic [1:0] KIND_START  = 2'd2;

	// result status codes
	localparam logic [2:0] STAT_IDLE       = 3'd0;
	localparam logic [2:0] STAT_PRIMING    = 3'd1;
	localparam logic [2:0] STAT_MOVING     = 3'd2;
	localparam logic [2:0] STAT_STEADYING  = 3'd3;
	localparam logic [2:0] STAT_SETTLED    = 3'd4;
	localparam logic [2:0] STAT_TIMEOUT_OK = 3'd5;
	localparam logic [2:0] STAT_TIMEOUT_RJ = 3'd6;

	// configuration register indexes
	localparam logic [2:0] REG_TARE      = 3'd0;
	localparam logic [2:0] REG_INV_SCALE = 3'd1;
	localparam logic [2:0] REG_SMOOTH_W  = 3'd2;
	localparam logic [2:0] REG_THRESHOLD = 3'd3;
	localparam logic [2:0] REG_WAIT_MS   = 3'd4;

	localparam logic [23:0] RST_TARE      = 24'd0;
	localparam logic [31:0] RST_INV_SCALE = 32'h0100_0000;
	localparam logic [15:0] RST_SMOOTH_W  = 16'd26214;
	localparam logic [31:0] RST_THRESHOLD = 32'd256;
	localparam logic [15:0] RST_WAIT_MS   = 16'd1000;

	localparam logic [23:0] SIGN_FLIP      = 24'h80_0000;
	localparam logic [16:0] ELAPSED_MAX    = 17'h1_FFFF;
	localparam logic [16:0] WEIGHT_ONE     = 17'h1_0000;
	localparam logic [1:0]  PRIME_SAMPLES  = 2'd2;
	localparam logic [2:0]  PARTIAL_ACCEPT = 3'd3;
	localparam logic [2:0]  SETTLE_COUNT   = 3'd5;
	localparam logic [2:0]  STILL_MAX      = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_SCALE,
		ST_SAT,
		ST_MUL_NEW,
		ST_MUL_OLD,
		ST_SUM,
		ST_DIFF,
		ST_FIN
	} lcsd_state_t;

	typedef enum logic [1:0] {
		FIN_START,
		FIN_IDLE,
		FIN_TIMEOUT,
		FIN_SMOOTH
	} lcsd_fin_t;

	typedef enum logic [1:0] {
		MUL_SCALE,
		MUL_NEW,
		MUL_OLD
	} lcsd_mul_t;

	typedef struct packed {
		logic       accept;
		logic       tick;
		logic       mul_en;
		lcsd_mul_t  mul_sel;
		logic       sat;
		logic       sum;
		logic       diff;
		logic       fin;
		lcsd_fin_t  fin_op;
	} lcsd_cmd_t;

	typedef struct packed {
		logic run_active;
		logic priming;
		logic timed_out;
		logic out_free;
	} lcsd_sts_t;

endpackage

`default_nettype wire

### rtl/core/lcsd_ctrl.sv
`default_nettype none

module lcsd_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	input  wire logic [1:0]         req_kind,
	output logic                    req_stall,
	input  wire lcsd_pkg::lcsd_sts_t sts,
	output lcsd_pkg::lcsd_cmd_t     ctl
);
	import lcsd_pkg::*;

	lcsd_state_t state_q, state_d;
	lcsd_fin_t   op_q, op_d;
	logic        accept;

	assign accept    = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= FIN_IDLE;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_kind)
						KIND_SAMPLE: begin
							if (!sts.run_active) begin
								state_d = ST_FIN;
								op_d    = FIN_IDLE;
							end else if (sts.priming || !sts.timed_out) begin
								state_d = ST_MUL_SCALE;
								op_d    = FIN_SMOOTH;
							end else begin
								state_d = ST_FIN;
								op_d    = FIN_TIMEOUT;
							end
						end
						KIND_START: begin
							state_d = ST_FIN;
							op_d    = FIN_START;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL_SCALE: state_d = ST_SAT;
			ST_SAT:       state_d = ST_MUL_NEW;
			ST_MUL_NEW:   state_d = ST_MUL_OLD;
			ST_MUL_OLD:   state_d = ST_SUM;
			ST_SUM:       state_d = ST_DIFF;
			ST_DIFF:      state_d = ST_FIN;
			ST_FIN: begin
				// hold until the result register can take the item
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl         = '0;
		ctl.mul_sel = MUL_SCALE;
		ctl.fin_op  = op_q;
		ctl.accept  = accept;
		ctl.tick    = accept && (req_kind == KIND_TICK);
		case (state_q)
			ST_MUL_SCALE: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_SCALE;
			end
			ST_SAT: ctl.sat = 1'b1;
			ST_MUL_NEW: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_NEW;
			end
			ST_MUL_OLD: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_OLD;
			end
			ST_SUM:  ctl.sum  = 1'b1;
			ST_DIFF: ctl.diff = 1'b1;
			ST_FIN:  ctl.fin  = sts.out_free;
			default: ctl.fin  = 1'b0;
		endcase
	end

`ifndef SYNTHESIS
	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) && !sts.out_free |=> (state_q == ST_FIN))
		else $error("finish step left while result register busy");

	a_start_fin: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req_kind == KIND_START) |=> (state_q == ST_FIN) && (op_q == FIN_START))
		else $error("start item not routed to finish step");

	a_timeout_path: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req_kind == KIND_SAMPLE) && sts.run_active && !sts.priming
		&& sts.timed_out |=> (state_q == ST_FIN) && (op_q == FIN_TIMEOUT))
		else $error("timed-out sample entered arithmetic path");
`endif

endmodule

`default_nettype wire

### rtl/core/lcsd_dp.sv
`default_nettype none

module lcsd_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [23:0]         req_raw_code,
	input  wire lcsd_pkg::lcsd_cmd_t ctl,
	output lcsd_pkg::lcsd_sts_t      sts,
	input  wire logic                cfg_wen,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output lcsd_pkg::lcsd_out_t      rsp
);
	import lcsd_pkg::*;

	// configuration
	logic [23:0] tare_q;
	logic [31:0] inv_q;
	logic [15:0] w_q;
	logic [31:0] thr_q;
	logic [15:0] limit_q;

	// run state
	logic [31:0] avg_q, prev_q;
	logic [2:0]  still_q;
	logic [16:0] elapsed_q;
	logic [1:0]  prime_q;
	logic        run_q;
	logic        rsp_valid_q;

	// arithmetic payload
	logic [23:0] net_q;
	logic [55:0] prod_q;
	logic [48:0] acc_q;
	logic [31:0] units_q;
	logic [31:0] change_q;
	lcsd_out_t   rsp_q;

	logic [23:0] ob;
	logic [23:0] net_d;
	logic [16:0] w_old;
	logic [31:0] mul_a;
	logic [23:0] mul_b;
	logic [55:0] prod_d;
	logic [48:0] sum_d;
	logic [31:0] avg_sum;

	logic [31:0] prev_d;
	logic [2:0]  still_d;
	logic [16:0] elapsed_d;
	logic [1:0]  prime_d;
	logic        run_d;
	lcsd_out_t   rsp_d;
	logic        still_hit;
	logic [2:0]  cnt_inc;

	assign ob    = req_raw_code ^ SIGN_FLIP;
	assign net_d = (ob > tare_q) ? (ob - tare_q) : 24'd0;
	assign w_old = WEIGHT_ONE - {1'b0, w_q};

	// one shared 32x24 multiplier
	always_comb begin
		case (ctl.mul_sel)
			MUL_SCALE: begin
				mul_a = inv_q;
				mul_b = net_q;
			end
			MUL_NEW: begin
				mul_a = units_q;
				mul_b = {8'd0, w_q};
			end
			MUL_OLD: begin
				mul_a = avg_q;
				mul_b = {7'd0, w_old};
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 24'd0;
			end
		endcase
	end

	assign prod_d  = 56'(mul_a) * 56'(mul_b);
	assign sum_d   = acc_q + prod_q[48:0];
	assign avg_sum = sum_d[47:16];

	assign sts.run_active = run_q;
	assign sts.priming    = (prime_q != 2'd0);
	assign sts.timed_out  = (elapsed_q > {1'b0, limit_q});
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

	always_comb begin
		still_hit = (change_q <= thr_q);
		cnt_inc   = (still_q != STILL_MAX) ? (still_q + 3'd1) : still_q;
		prev_d    = prev_q;
		still_d   = still_q;
		elapsed_d = elapsed_q;
		prime_d   = prime_q;
		run_d     = run_q;
		rsp_d.status      = STAT_IDLE;
		rsp_d.weight      = avg_q;
		rsp_d.still_count = still_q;
		if (ctl.tick && run_q && (elapsed_q != ELAPSED_MAX)) begin
			elapsed_d = elapsed_q + 17'd1;
		end
		if (ctl.fin) begin
			case (ctl.fin_op)
				FIN_START: begin
					elapsed_d = 17'd0;
					still_d   = 3'd0;
					prime_d   = PRIME_SAMPLES;
					run_d     = 1'b1;
					rsp_d.status      = STAT_PRIMING;
					rsp_d.still_count = 3'd0;
				end
				FIN_IDLE: rsp_d.status = STAT_IDLE;
				FIN_TIMEOUT: begin
					run_d = 1'b0;
					if (still_q >= PARTIAL_ACCEPT) begin
						rsp_d.status = STAT_TIMEOUT_OK;
					end else begin
						rsp_d.status = STAT_TIMEOUT_RJ;
						rsp_d.weight = 32'd0;
					end
				end
				FIN_SMOOTH: begin
					if (prime_q != 2'd0) begin
						prime_d = prime_q - 2'd1;
						// last priming sample seeds the previous average
						if (prime_q == 2'd1) begin
							prev_d = avg_q;
						end
						rsp_d.status = STAT_PRIMING;
					end else begin
						prev_d = avg_q;
						if (still_hit) begin
							still_d           = cnt_inc;
							rsp_d.still_count = cnt_inc;
							if (cnt_inc >= SETTLE_COUNT) begin
								run_d        = 1'b0;
								rsp_d.status = STAT_SETTLED;
							end else begin
								rsp_d.status = STAT_STEADYING;
							end
						end else begin
							still_d           = 3'd0;
							rsp_d.still_count = 3'd0;
							rsp_d.status      = STAT_MOVING;
						end
					end
				end
				default: rsp_d.status = STAT_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_q      <= RST_TARE;
			inv_q       <= RST_INV_SCALE;
			w_q         <= RST_SMOOTH_W;
			thr_q       <= RST_THRESHOLD;
			limit_q     <= RST_WAIT_MS;
			avg_q       <= 32'd0;
			prev_q      <= 32'd0;
			still_q     <= 3'd0;
			elapsed_q   <= 17'd0;
			prime_q     <= 2'd0;
			run_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_TARE:      tare_q  <= cfg_data[23:0];
					REG_INV_SCALE: inv_q   <= cfg_data;
					REG_SMOOTH_W:  w_q     <= cfg_data[15:0];
					REG_THRESHOLD: thr_q   <= cfg_data;
					REG_WAIT_MS:   limit_q <= cfg_data[15:0];
					default:       tare_q  <= tare_q;
				endcase
			end
			if (ctl.sum) begin
				// seed from the sample while the average is zero
				avg_q <= (avg_q == 32'd0) ? units_q : avg_sum;
			end
			prev_q    <= prev_d;
			still_q   <= still_d;
			elapsed_q <= elapsed_d;
			prime_q   <= prime_d;
			run_q     <= run_d;
			if (ctl.fin) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			net_q <= net_d;
		end
		if (ctl.mul_en) begin
			prod_q <= prod_d;
		end
		if (ctl.mul_en && (ctl.mul_sel == MUL_OLD)) begin
			acc_q <= prod_q[48:0];
		end
		if (ctl.sat) begin
			units_q <= (prod_q[55:48] != 8'd0) ? 32'hFFFF_FFFF : prod_q[47:16];
		end
		if (ctl.diff) begin
			change_q <= (avg_q >= prev_q) ? (avg_q - prev_q) : (prev_q - avg_q);
		end
		if (ctl.fin) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |=> rsp_valid_q)
		else $error("finish step produced no result");

	a_still_bound: assert property (@(posedge clk) disable iff (!arst_n)
		still_q <= SETTLE_COUNT)
		else $error("still counter ran past settle count");

	a_prime_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> (prime_q == 2'd0) || $past(run_q))
		else $error("priming pending without a run");
`endif

endmodule

`default_nettype wire

### rtl/core/load_cell_settling_detector.sv
// A start item, or an idle or timed-out sample, goes through the finish step to
// the result register; a sample that updates the average first passes the scale
// multiply, saturate, new and old weight multiply, sum and difference steps
// (three passes through one shared 32x24 multiplier). Ticks are taken one per
// cycle while idle; no item is taken while another is in flight. A held result
// stalls the next item only at its finish step. arst_n clears the run state, the
// average and the result valid; configuration registers return to their defaults.
`default_nettype none

module load_cell_settling_detector (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire lcsd_pkg::lcsd_in_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output lcsd_pkg::lcsd_out_t     rsp,
	input  wire logic               cfg_wen,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import lcsd_pkg::*;

	lcsd_cmd_t ctl;
	lcsd_sts_t sts;

	lcsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_kind  (req.kind),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	lcsd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_raw_code (req.raw_code),
		.ctl          (ctl),
		.sts          (sts),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp)
	);

endmodule

`default_nettype wire
